### sv/robin_hood_hash_table_top_assert.svh
// Assertion macros for the Robin Hood hash table.
// Used by robin_hood_hash_table_top.sv; no other dependencies.
`ifndef ROBIN_HOOD_HASH_TABLE_TOP_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RH_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define RH_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

### sv/rhht_pkg.sv
// Package for the Robin Hood hash table: constants, commands, sequencer states.
// No dependencies.
package rhht_pkg;
  localparam int BUCKETS_DEF = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam logic [63:0] HASH_BASIS = 64'd2166136261;
  localparam logic [63:0] HASH_MUL = 64'hbf58476d1ce4e5b9;
  localparam logic [10:0] LIMIT_RESET = 11'd768;
  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] ADDR_ENTRY_LIMIT = 2'd0;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH0, ST_HASH1, ST_HASH2, ST_HASH3, ST_HASH4,
    ST_LREAD, ST_LCHECK, ST_IREAD, ST_ICHECK, ST_RREAD, ST_RCHECK, ST_RCLEAR,
    ST_DONE
  } state_t;
endpackage

### sv/robin_hood_hash_table_top.sv
// Robin Hood hash table top level: sequencer, hash unit and bucket memories.
// Depends on rhht_pkg and robin_hood_hash_table_top_assert.svh.
//
// The block is a Robin Hood open-addressing table of 64-bit keys. One
// transaction on the input channel carries a set, get or remove command and
// produces exactly one result transaction. A single sequencer handles one
// command at a time and is not ready while it works. The hash computes the
// three 32x32 partial products of the 64-bit multiply one after another, then
// the fold and the bucket select. Every probed bucket is then first read from
// the bucket memories (registered read) and then compared and, for insert and
// remove, written back. An insert visits every bucket from its insertion
// point up to and including the empty bucket that ends it. A remove examines
// every bucket after the removed one up to the one that ends the shift, and
// empties one more bucket in the rare case where the shift runs around the
// whole table. After reset the block clears the probe lengths of all BUCKETS
// (1024) buckets, one bucket per cycle, with in_ready low.
// The entry_limit register lies at APB address 0; pready is always high and
// reads return the register value.
`include "robin_hood_hash_table_top_assert.svh"
module robin_hood_hash_table_top #(
  parameter int VALUE_BITS = rhht_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [63:0] key,
  input  logic [31:0] value,
  input  logic        value_given,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [31:0] read_value,
  output logic        read_present,
  output logic        status,
  output logic [10:0] entry_total
);
  localparam int BUCKETS = rhht_pkg::BUCKETS_DEF;
  localparam int AW = $clog2(BUCKETS);
  localparam int PW = AW + 1;
  localparam int CW = $clog2(BUCKETS + 1);

  // Configuration register.
  logic [10:0] entry_limit;
  assign pready = 1'b1;
  assign prdata = (paddr == rhht_pkg::ADDR_ENTRY_LIMIT) ? {21'd0, entry_limit} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= rhht_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == rhht_pkg::ADDR_ENTRY_LIMIT) begin
      entry_limit <= pwdata[10:0];
    end
  end

  // Bucket memories. A bucket is occupied when its probe length is nonzero;
  // the probe lengths are cleared by the pass that follows reset.
  logic [PW-1:0]         plen_mem [BUCKETS];
  logic [63:0]           key_mem  [BUCKETS];
  logic [VALUE_BITS-1:0] val_mem  [BUCKETS];
  logic                  flag_mem [BUCKETS];

  logic [AW-1:0]         rd_addr;
  logic                  rd_en;
  logic [63:0]           rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  rd_flag;
  logic [PW-1:0]         rd_plen;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [PW-1:0]         wr_plen;
  logic [63:0]           wr_key;
  logic [VALUE_BITS-1:0] wr_val;
  logic                  wr_flag;
  logic                  wr_data;   // write key and value as well as plen

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_plen <= plen_mem[rd_addr];
      rd_key  <= key_mem[rd_addr];
      rd_val  <= val_mem[rd_addr];
      rd_flag <= flag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      plen_mem[wr_addr] <= wr_plen;
      if (wr_data) begin
        key_mem[wr_addr] <= wr_key;
        val_mem[wr_addr] <= wr_val;
      end
      flag_mem[wr_addr] <= wr_flag;
    end
  end

  // Command registers.
  logic [1:0]            c_cmd;
  logic [63:0]           c_key;
  logic [VALUE_BITS-1:0] c_val;
  logic                  c_flag;

  // Shared 32x32 multiplier for the hash, one partial product per cycle.
  logic [63:0] hx;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] hacc;
  assign hx = rhht_pkg::HASH_BASIS ^ c_key;
  assign mul_p = mul_a * mul_b;

  rhht_pkg::state_t state, state_next;

  always_comb begin
    mul_a = hx[31:0];
    mul_b = rhht_pkg::HASH_MUL[31:0];
    case (state)
      rhht_pkg::ST_HASH1: begin mul_a = hx[31:0];  mul_b = rhht_pkg::HASH_MUL[63:32]; end
      rhht_pkg::ST_HASH2: begin mul_a = hx[63:32]; mul_b = rhht_pkg::HASH_MUL[31:0];  end
      default: begin mul_a = hx[31:0]; mul_b = rhht_pkg::HASH_MUL[31:0]; end
    endcase
  end

  // Working registers of the probe loop.
  logic [AW-1:0]         idx;
  logic [PW-1:0]         p;
  logic [CW-1:0]         n;        // buckets visited so far
  logic                  have;
  logic [AW-1:0]         ins;
  logic [PW-1:0]         ins_len;
  logic [63:0]           ck;       // carried entry for displacement
  logic [VALUE_BITS-1:0] cv;
  logic                  cf;
  logic [10:0]           count;
  logic [AW-1:0]         clr_addr; // bucket cleared by the pass after reset

  logic                  r_found, r_pres, r_status;
  logic [31:0]           r_val;

  logic [AW-1:0]         idx_inc;
  logic                  last_n;
  logic                  key_hit;
  logic                  full_now;
  assign idx_inc  = (idx == AW'(BUCKETS - 1)) ? '0 : idx + 1'b1;
  assign last_n   = (n == CW'(BUCKETS - 1));
  assign key_hit  = (rd_plen != '0) && (rd_key == c_key);
  assign full_now = (count >= entry_limit) || ({1'b0, count} >= 12'(BUCKETS));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rhht_pkg::ST_CLEAR: if (clr_addr == AW'(BUCKETS - 1)) state_next = rhht_pkg::ST_IDLE;
      rhht_pkg::ST_IDLE:  if (in_valid) state_next = rhht_pkg::ST_HASH0;
      rhht_pkg::ST_HASH0: state_next = rhht_pkg::ST_HASH1;
      rhht_pkg::ST_HASH1: state_next = rhht_pkg::ST_HASH2;
      rhht_pkg::ST_HASH2: state_next = rhht_pkg::ST_HASH3;
      rhht_pkg::ST_HASH3: state_next = rhht_pkg::ST_HASH4;
      rhht_pkg::ST_HASH4: state_next = (c_cmd == rhht_pkg::CMD_UNUSED) ? rhht_pkg::ST_DONE
                                                                        : rhht_pkg::ST_LREAD;
      rhht_pkg::ST_LREAD: state_next = rhht_pkg::ST_LCHECK;
      rhht_pkg::ST_LCHECK: begin
        if (rd_plen == '0 || key_hit || last_n) begin
          if (key_hit && c_cmd == rhht_pkg::CMD_REMOVE) begin
            state_next = (BUCKETS > 1) ? rhht_pkg::ST_RREAD : rhht_pkg::ST_DONE;
          end else if (!key_hit && c_cmd == rhht_pkg::CMD_SET && !full_now) begin
            state_next = rhht_pkg::ST_IREAD;
          end else begin
            state_next = rhht_pkg::ST_DONE;
          end
        end else begin
          state_next = rhht_pkg::ST_LREAD;
        end
      end
      rhht_pkg::ST_IREAD:  state_next = rhht_pkg::ST_ICHECK;
      rhht_pkg::ST_ICHECK: state_next = (rd_plen == '0 || last_n) ? rhht_pkg::ST_DONE
                                                                  : rhht_pkg::ST_IREAD;
      rhht_pkg::ST_RREAD:  state_next = rhht_pkg::ST_RCHECK;
      rhht_pkg::ST_RCHECK: begin
        if (rd_plen <= PW'(1)) begin
          state_next = rhht_pkg::ST_DONE;
        end else if (last_n) begin
          state_next = rhht_pkg::ST_RCLEAR;
        end else begin
          state_next = rhht_pkg::ST_RREAD;
        end
      end
      rhht_pkg::ST_RCLEAR: state_next = rhht_pkg::ST_DONE;
      rhht_pkg::ST_DONE:   if (out_ready) state_next = rhht_pkg::ST_IDLE;
      default: state_next = rhht_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshakes, memory port controls.
  logic [AW-1:0] rnext;  // bucket read in the remove shift
  assign rnext = idx_inc;
  always_comb begin
    in_ready  = (state == rhht_pkg::ST_IDLE);
    out_valid = (state == rhht_pkg::ST_DONE);
    rd_en     = 1'b0;
    rd_addr   = idx;
    wr_en     = 1'b0;
    wr_addr   = idx;
    wr_plen   = p;
    wr_key    = ck;
    wr_val    = cv;
    wr_flag   = cf;
    wr_data   = 1'b1;
    case (state)
      rhht_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_plen = '0;
        wr_data = 1'b0;
      end
      rhht_pkg::ST_LREAD, rhht_pkg::ST_IREAD: rd_en = 1'b1;
      rhht_pkg::ST_RREAD: begin rd_en = 1'b1; rd_addr = rnext; end
      rhht_pkg::ST_LCHECK: begin
        if (key_hit && c_cmd == rhht_pkg::CMD_SET) begin
          // Update in place: value and flag only.
          wr_en   = 1'b1;
          wr_plen = rd_plen;
          wr_val  = c_flag ? c_val : '0;
          wr_flag = c_flag;
          wr_key  = rd_key;
          wr_data = 1'b1;
        end else if (key_hit && c_cmd == rhht_pkg::CMD_REMOVE && BUCKETS <= 1) begin
          wr_en   = 1'b1;
          wr_plen = '0;
          wr_data = 1'b0;
          wr_flag = rd_flag;
        end
      end
      rhht_pkg::ST_ICHECK: begin
        if (rd_plen == '0 || p > rd_plen) begin
          wr_en = 1'b1;
        end
      end
      rhht_pkg::ST_RCHECK: begin
        wr_en = 1'b1;
        if (rd_plen <= PW'(1)) begin
          wr_plen = '0;
          wr_data = 1'b0;
          wr_flag = rd_flag;
        end else begin
          wr_plen = rd_plen - 1'b1;
          wr_key  = rd_key;
          wr_val  = rd_val;
          wr_flag = rd_flag;
        end
      end
      rhht_pkg::ST_RCLEAR: begin
        // The shift went around the whole table: empty the last bucket moved.
        wr_en   = 1'b1;
        wr_plen = '0;
        wr_data = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rhht_pkg::ST_CLEAR;
      count    <= '0;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == rhht_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == rhht_pkg::ST_ICHECK && rd_plen == '0) begin
        count <= count + 1'b1;
      end else if ((state == rhht_pkg::ST_LCHECK && key_hit &&
                    c_cmd == rhht_pkg::CMD_REMOVE) && count != '0) begin
        count <= count - 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      rhht_pkg::ST_IDLE: begin
        if (in_valid) begin
          c_cmd  <= cmd;
          c_key  <= key;
          c_val  <= VALUE_BITS'(value);
          c_flag <= value_given;
        end
        r_found  <= 1'b0;
        r_pres   <= 1'b0;
        r_status <= 1'b0;
        r_val    <= '0;
      end
      rhht_pkg::ST_HASH0: hacc <= mul_p;
      rhht_pkg::ST_HASH1: hacc <= hacc + {mul_p[31:0], 32'd0};
      rhht_pkg::ST_HASH2: hacc <= hacc + {mul_p[31:0], 32'd0};
      rhht_pkg::ST_HASH3: hacc <= hacc ^ {32'd0, hacc[63:32]};
      rhht_pkg::ST_HASH4: begin
        idx  <= hacc[AW-1:0];
        p    <= PW'(1);
        n    <= '0;
        have <= 1'b0;
        ins  <= hacc[AW-1:0];
        ins_len <= PW'(1);
      end
      rhht_pkg::ST_LCHECK: begin
        if (!have && p > rd_plen) begin
          ins <= idx;
          ins_len <= p;
          have <= 1'b1;
        end
        if (key_hit) begin
          r_found <= 1'b1;
          if (c_cmd == rhht_pkg::CMD_GET && rd_flag) begin
            r_pres <= 1'b1;
            r_val  <= 32'(rd_val);
          end
        end else if (rd_plen == '0 || last_n) begin
          if (c_cmd == rhht_pkg::CMD_SET && full_now) r_status <= 1'b1;
        end
        if (key_hit || rd_plen == '0 || last_n) begin
          // The shift of a remove examines at most BUCKETS - 1 buckets.
          n <= (key_hit && c_cmd == rhht_pkg::CMD_REMOVE) ? CW'(1) : '0;
          if (!key_hit) begin
            idx <= (!have && p > rd_plen) ? idx : ins;
            p   <= (!have && p > rd_plen) ? p : ins_len;
          end
          ck <= c_key;
          cv <= c_flag ? c_val : '0;
          cf <= c_flag;
        end else begin
          n   <= n + 1'b1;
          p   <= p + 1'b1;
          idx <= idx_inc;
        end
      end
      rhht_pkg::ST_ICHECK: begin
        n   <= n + 1'b1;
        idx <= idx_inc;
        if (rd_plen != '0 && p > rd_plen) begin
          ck <= rd_key;
          cv <= rd_val;
          cf <= rd_flag;
          p  <= rd_plen + 1'b1;
        end else begin
          p  <= p + 1'b1;
        end
      end
      rhht_pkg::ST_RCHECK: begin
        n   <= n + 1'b1;
        idx <= rnext;
      end
      default: ;
    endcase
  end

  assign found        = r_found;
  assign read_value   = r_val;
  assign read_present = r_pres;
  assign status       = r_status;
  assign entry_total  = count;

  `RH_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, !out_valid, "ready while result pending")
  `RH_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, {1'b0, count} <= 12'(BUCKETS), "count overflow")
  `RH_ASSERT_IMP(a_pres_found, clk, rst, out_valid && read_present, found,
                 "value present without key found")
  `RH_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready,
                  "block ready right after accepting")
endmodule
